### rtl/core/ios_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the I/O request splitter.
// No dependencies; imported by every module of the splitter.
package ios_pkg;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_MISALIGNED = 2'd1;
    localparam logic [1:0] ST_EMPTY      = 2'd2;
    localparam logic [1:0] ST_TOO_MANY   = 2'd3;

    localparam logic [7:0] OPC_WRITE = 8'd1;
    localparam logic [7:0] OPC_READ  = 8'd2;

    typedef struct packed {
        logic [63:0] buffer_address;
        logic [31:0] size_bytes;
        logic [63:0] start_lba;
        logic        write_op;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] command_lba;
        logic [3:0]  blocks_minus_one;
        logic [7:0]  opcode;
        logic [63:0] chunk_address;
        logic [5:0]  queue_id;
        logic        last;
    } t_rsp;

    // checked request handed from the check stage to the splitter
    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] buffer_address;
        logic [63:0] start_lba;
        logic [31:0] blocks;
        logic        write_op;
    } t_chk;

endpackage

### rtl/core/io_request_splitter_top.sv
`timescale 1ns / 1ps
// Top level of the I/O request splitter: config register, stages, output register.
// Depends on ios_pkg, ios_check and ios_split.

// Splits a host read/write request into I/O commands of at most MAX_CMD_BYTES.
// A request passes a check stage, a split stage and an output register, each
// registered. The split stage issues one result per cycle while the output
// register takes it (i_rsp_ready or empty): a request of n chunks (at most
// MAX_BATCH) gives n results, an error request one; the check stage takes the
// next request meanwhile. BLOCK_BYTES must be a power of two. queue_count is
// clamped to 2..64; commands of each request go round-robin from queue 1.
module io_request_splitter_top
    import ios_pkg::*;
#(
    parameter int BLOCK_BYTES   = 4096,
    parameter int MAX_CMD_BYTES = 65536,
    parameter int MAX_BATCH     = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  t_req       i_req,
    output logic       o_rsp_valid,
    input  logic       i_rsp_ready,
    output t_rsp       o_rsp,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_wdata
);

    localparam int BPC = (MAX_CMD_BYTES / BLOCK_BYTES) == 0 ? 1
                                                       : MAX_CMD_BYTES / BLOCK_BYTES;

    logic [6:0] r_queue_count;
    logic [5:0] w_qmax;

    logic       w_chk_valid;
    logic       w_chk_ready;
    t_chk       w_chk;
    logic       w_spl_valid;
    logic       w_spl_ready;
    t_rsp       w_spl_rsp;

    logic       r_out_valid;
    t_rsp       r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_count <= 7'd2;
        end else if (i_cfg_we) begin
            r_queue_count <= i_cfg_wdata;
        end
    end

    // highest queue id in use
    always_comb begin
        priority if (r_queue_count < 7'd2) begin
            w_qmax = 6'd1;
        end else if (r_queue_count > 7'd64) begin
            w_qmax = 6'd63;
        end else begin
            w_qmax = 6'(r_queue_count - 7'd1);
        end
    end

    ios_check #(
        .BLOCK_BYTES   (BLOCK_BYTES),
        .MAX_CMD_BYTES (MAX_CMD_BYTES),
        .MAX_BATCH     (MAX_BATCH)
    ) u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req_valid),
        .o_ready (o_req_ready),
        .i_req   (i_req),
        .o_valid (w_chk_valid),
        .i_ready (w_chk_ready),
        .o_chk   (w_chk)
    );

    ios_split #(
        .BLOCK_BYTES   (BLOCK_BYTES),
        .MAX_CMD_BYTES (MAX_CMD_BYTES)
    ) u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_chk_valid),
        .o_ready (w_chk_ready),
        .i_chk   (w_chk),
        .i_qmax  (w_qmax),
        .o_valid (w_spl_valid),
        .i_ready (w_spl_ready),
        .o_rsp   (w_spl_rsp)
    );

    assign w_spl_ready = !r_out_valid || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_spl_ready) begin
            r_out_valid <= w_spl_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_spl_ready && w_spl_valid) begin
            r_out <= w_spl_rsp;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status != ST_OK) |-> o_rsp.last)
        else $error("error request not marked last");

    a_cmd_qid_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status == ST_OK) |-> (o_rsp.queue_id != 6'd0))
        else $error("command routed to admin queue");

    // a non-last command taken: the next result is the following chunk
    a_chunk_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(o_rsp_valid && i_rsp_ready && !o_rsp.last)
            && o_rsp_valid)
        |-> (o_rsp.status == ST_OK
            && o_rsp.command_lba == $past(o_rsp.command_lba) + 64'(BPC)))
        else $error("chunk sequence broken");

endmodule

### rtl/core/ios_check.sv
`timescale 1ns / 1ps
// Check stage: classifies a request (misaligned, empty, too many commands).
// Depends on ios_pkg.
module ios_check
    import ios_pkg::*;
#(
    parameter int BLOCK_BYTES   = 4096,
    parameter int MAX_CMD_BYTES = 65536,
    parameter int MAX_BATCH     = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_chk o_chk
);

    localparam int LOG2B = $clog2(BLOCK_BYTES);
    localparam int BPC   = (MAX_CMD_BYTES / BLOCK_BYTES) == 0 ? 1
                                                         : MAX_CMD_BYTES / BLOCK_BYTES;
    localparam logic [32:0] LIMIT = 33'(MAX_BATCH * BPC);

    logic        r_valid;
    t_chk        r_chk;
    t_chk        n_chk;
    logic [32:0] w_nblk;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_chk   = r_chk;

    assign w_nblk = 33'(i_req.size_bytes >> LOG2B);

    always_comb begin
        n_chk.buffer_address = i_req.buffer_address;
        n_chk.start_lba      = i_req.start_lba;
        n_chk.blocks         = i_req.size_bytes >> LOG2B;
        n_chk.write_op       = i_req.write_op;
        priority if (|i_req.size_bytes[LOG2B-1:0]) begin
            n_chk.status = ST_MISALIGNED;
        end else if (i_req.buffer_address == 64'd0 || i_req.size_bytes == 32'd0) begin
            n_chk.status = ST_EMPTY;
        end else if (w_nblk > LIMIT) begin
            n_chk.status = ST_TOO_MANY;
        end else begin
            n_chk.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_chk <= n_chk;
        end
    end

endmodule

### rtl/core/ios_split.sv
`timescale 1ns / 1ps
// Split stage: walks a checked request, one command per cycle while i_ready is high.
// Depends on ios_pkg.
module ios_split
    import ios_pkg::*;
#(
    parameter int BLOCK_BYTES   = 4096,
    parameter int MAX_CMD_BYTES = 65536
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_chk       i_chk,
    input  logic [5:0] i_qmax,
    output logic       o_valid,
    input  logic       i_ready,
    output t_rsp       o_rsp
);

    localparam int LOG2B = $clog2(BLOCK_BYTES);
    localparam int NBW   = 32 - LOG2B;
    localparam int BPC   = (MAX_CMD_BYTES / BLOCK_BYTES) == 0 ? 1
                                                         : MAX_CMD_BYTES / BLOCK_BYTES;
    localparam logic [NBW-1:0] BPC_N  = NBW'(BPC);
    localparam logic [63:0]    BPC_64 = 64'(BPC);
    localparam logic [63:0]    CHUNK  = 64'(BPC) * 64'(BLOCK_BYTES);

    logic           r_busy;
    logic [1:0]     r_status;
    logic [63:0]    r_lba;
    logic [63:0]    r_addr;
    logic [NBW-1:0] r_rem;
    logic [5:0]     r_qid;
    logic           r_wr;

    logic           w_fire;
    logic           w_final;
    logic           w_load;
    logic [NBW-1:0] w_blk;
    logic [NBW-1:0] w_blk_m1;

    assign w_fire  = r_busy && i_ready;
    assign w_final = (r_status != ST_OK) || (r_rem <= BPC_N);
    assign o_ready = !r_busy || (w_fire && w_final);
    assign w_load  = o_ready && i_valid;
    assign o_valid = r_busy;

    assign w_blk    = (r_rem < BPC_N) ? r_rem : BPC_N;
    assign w_blk_m1 = w_blk - NBW'(1);

    always_comb begin
        o_rsp.status = r_status;
        o_rsp.last   = w_final;
        if (r_status == ST_OK) begin
            o_rsp.command_lba      = r_lba;
            o_rsp.blocks_minus_one = w_blk_m1[3:0];
            o_rsp.opcode           = r_wr ? OPC_WRITE : OPC_READ;
            o_rsp.chunk_address    = r_addr;
            o_rsp.queue_id         = r_qid;
        end else begin
            o_rsp.command_lba      = 64'd0;
            o_rsp.blocks_minus_one = 4'd0;
            o_rsp.opcode           = 8'd0;
            o_rsp.chunk_address    = 64'd0;
            o_rsp.queue_id         = 6'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_load) begin
            r_busy <= 1'b1;
        end else if (w_fire && w_final) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status <= i_chk.status;
            r_lba    <= i_chk.start_lba;
            r_addr   <= i_chk.buffer_address;
            r_rem    <= i_chk.blocks[NBW-1:0];
            r_qid    <= 6'd1;
            r_wr     <= i_chk.write_op;
        end else if (w_fire) begin
            r_rem  <= r_rem - BPC_N;
            r_lba  <= r_lba + BPC_64;
            r_addr <= r_addr + CHUNK;
            // round-robin over queues 1..qmax
            r_qid  <= (r_qid >= i_qmax) ? 6'd1 : r_qid + 6'd1;
        end
    end

endmodule
